// ===== sv/csfh_pkg.sv =====
// ----------------------------------------------------------------------------
// csfh_pkg - shared types and constants of the compass sample filter
// Request kinds, the front-to-back queue entry, CORDIC widths and the
// arctangent table.
// ----------------------------------------------------------------------------
package csfh_pkg;

  // Configuration register indexes
  localparam logic [3:0] REG_OFFSET_X   = 4'd0;
  localparam logic [3:0] REG_OFFSET_Y   = 4'd1;
  localparam logic [3:0] REG_GATE_LIMIT = 4'd2;
  localparam logic [3:0] REG_ALPHA      = 4'd3;

  localparam logic [14:0] GATE_LIMIT_RESET = 15'd500;
  localparam logic [16:0] ALPHA_RESET      = 17'd13107;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // CORDIC datapath widths: x/y hold sample * 2^14 plus gain, z holds Q30 angle
  localparam int XY_W = 34;
  localparam int Z_W  = 35;
  localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic [15:0] HEADING_MAX = 16'd25736;

  // What the back end does with a request
  typedef enum logic [1:0] {
    KIND_LOAD,    // first request after reset: filters take the sample
    KIND_UPDATE,  // passed the gate: filters move toward the sample
    KIND_REJECT   // outside the gate: filters hold
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
  } item_t;

  // Arctangent of 2^-i in Q30, truncated
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      0:  v = 35'sd843314856;
      1:  v = 35'sd497837829;
      2:  v = 35'sd263043836;
      3:  v = 35'sd133525158;
      4:  v = 35'sd67021686;
      5:  v = 35'sd33543515;
      6:  v = 35'sd16775850;
      7:  v = 35'sd8388437;
      8:  v = 35'sd4194282;
      9:  v = 35'sd2097149;
      10: v = 35'sd1048575;
      11: v = 35'sd524287;
      12: v = 35'sd262143;
      13: v = 35'sd131071;
      14: v = 35'sd65535;
      15: v = 35'sd32767;
      16: v = 35'sd16383;
      17: v = 35'sd8191;
      18: v = 35'sd4095;
      19: v = 35'sd2047;
      20: v = 35'sd1023;
      21: v = 35'sd511;
      22: v = 35'sd255;
      23: v = 35'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/csfh_front.sv =====
// ----------------------------------------------------------------------------
// csfh_front - offset correction and gate classification
// Adds calibration offsets, checks both axes against the gate and tags each
// request as load, update or reject before it enters the queue.
// ----------------------------------------------------------------------------
module csfh_front import csfh_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic        [15:0] offset_x,
  input  logic        [15:0] offset_y,
  input  logic        [14:0] gate_limit,
  input  logic               push,
  output item_t              item
);

  logic               primed;
  logic signed [15:0] cx;
  logic signed [15:0] cy;
  logic signed [16:0] cx_w;
  logic signed [16:0] cy_w;
  logic signed [16:0] lim;
  logic               in_gate;

  // Correct with 16-bit wrap and compare against +/- gate_limit
  always_comb begin
    cx      = raw_x + $signed(offset_x);
    cy      = raw_y + $signed(offset_y);
    cx_w    = {cx[15], cx};
    cy_w    = {cy[15], cy};
    lim     = $signed({2'b00, gate_limit});
    in_gate = (cx_w >= -lim) && (cx_w <= lim) && (cy_w >= -lim) && (cy_w <= lim);
    item.cx = cx;
    item.cy = cy;
    priority if (!primed) begin
      item.kind = KIND_LOAD;
    end else if (in_gate) begin
      item.kind = KIND_UPDATE;
    end else begin
      item.kind = KIND_REJECT;
    end
  end

  // Set primed on the first request
  always_ff @(posedge clk) begin
    if (rst) begin
      primed <= 1'b0;
    end else if (push) begin
      primed <= 1'b1;
    end
  end

endmodule

// ===== sv/csfh_queue.sv =====
// ----------------------------------------------------------------------------
// csfh_queue - short request queue between front and back
// Small FIFO of classified requests; lets either side stall on its own.
// ----------------------------------------------------------------------------
module csfh_queue import csfh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  not_empty
);

  item_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr;
  logic [QUEUE_AW-1:0]    rd_ptr;
  logic [QUEUE_AW:0]      count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/csfh_filter.sv =====
// ----------------------------------------------------------------------------
// csfh_filter - exponential moving average per axis
// Pops one request per cycle while the output side advances, and updates the filter state with a single
// multiply-add per axis: f + alpha*(s - f), truncated toward zero.
// ----------------------------------------------------------------------------
module csfh_filter import csfh_pkg::*; #(
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic        [16:0] alpha,
  input  item_t              item,
  input  logic               item_valid,
  input  logic               adv,
  output logic               pop,
  output logic               out_valid,
  output logic signed [15:0] filter_x,
  output logic signed [15:0] filter_y,
  output logic               accepted
);

  localparam int F     = ALPHA_FRAC_BITS;
  localparam int AX    = (F + 1 > 17) ? F + 1 : 17;
  localparam int ACC_W = F + 19;

  logic [AX-1:0] alpha_ext;
  logic [AX-1:0] one_ext;
  logic [AX-1:0] alpha_sat;
  logic [F:0]    a_eff;
  logic signed [15:0] next_x;
  logic signed [15:0] next_y;

  // Saturate alpha at one
  always_comb begin
    alpha_ext = AX'(alpha);
    one_ext   = AX'(1) << F;
    alpha_sat = (alpha_ext > one_ext) ? one_ext : alpha_ext;
    a_eff     = alpha_sat[F:0];
  end

  function automatic logic signed [15:0] smooth(input logic signed [15:0] s,
                                                input logic signed [15:0] f,
                                                input logic [F:0] a);
    logic signed [16:0]      diff;
    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] q;
    diff = {s[15], s} - {f[15], f};
    prod = ACC_W'(diff) * $signed(ACC_W'({1'b0, a}));
    acc  = (ACC_W'(f) <<< F) + prod;
    if (acc < 0) begin
      acc = acc + $signed((ACC_W'(1) << F) - ACC_W'(1));
    end
    q = acc >>> F;
    return q[15:0];
  endfunction

  assign next_x = smooth(item.cx, filter_x, a_eff);
  assign next_y = smooth(item.cy, filter_y, a_eff);
  assign pop    = adv && item_valid;

  // Update filter state and stage flags
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_x  <= '0;
      filter_y  <= '0;
      out_valid <= 1'b0;
      accepted  <= 1'b0;
    end else if (adv) begin
      out_valid <= item_valid;
      if (item_valid) begin
        unique case (item.kind)
          KIND_LOAD: begin
            filter_x <= item.cx;
            filter_y <= item.cy;
            accepted <= 1'b1;
          end
          KIND_UPDATE: begin
            filter_x <= next_x;
            filter_y <= next_y;
            accepted <= 1'b1;
          end
          default: begin
            accepted <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

// ===== sv/csfh_cordic.sv =====
// ----------------------------------------------------------------------------
// csfh_cordic - pipelined vectoring CORDIC heading and result register
// Quadrant fold, one micro-rotation per stage, then rounding to Q3.13 into
// the result register that drives the output channel.
// ----------------------------------------------------------------------------
module csfh_cordic import csfh_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic               in_accepted,
  output logic               out_valid,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_heading,
  output logic               out_accepted
);

  logic                     v_s   [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]   x_s   [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]   y_s   [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]    z_s   [CORDIC_STEPS+1];
  logic signed [15:0]       sx_s  [CORDIC_STEPS+1];
  logic signed [15:0]       sy_s  [CORDIC_STEPS+1];
  logic                     acc_s [CORDIC_STEPS+1];
  logic                     zero_s[CORDIC_STEPS+1];

  logic signed [XY_W-1:0]   x0;
  logic signed [XY_W-1:0]   y0;
  logic signed [Z_W-1:0]    z0;
  logic signed [Z_W-1:0]    zf;
  logic        [Z_W-1:0]    mag;
  logic        [Z_W-1:0]    rnd;
  logic        [15:0]       r;
  logic signed [15:0]       heading;

  // Scale by 2^14 and fold the left half-plane by pi
  always_comb begin
    x0 = XY_W'(in_x) <<< 14;
    y0 = XY_W'(in_y) <<< 14;
    z0 = '0;
    if (in_x < 0) begin
      z0 = (in_y >= 0) ? PI_Q30 : -PI_Q30;
      x0 = -x0;
      y0 = -y0;
    end
  end

  // Fold stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (adv) begin
      v_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_s[0]    <= x0;
      y_s[0]    <= y0;
      z_s[0]    <= z0;
      sx_s[0]   <= in_x;
      sy_s[0]   <= in_y;
      acc_s[0]  <= in_accepted;
      zero_s[0] <= (in_x == '0) && (in_y == '0);
    end
  end

  // Micro-rotation stages, shifts floor toward minus infinity
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (adv) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (y_s[i] >= 0) begin
          x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] + atan_q30(i);
        end else begin
          x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] - atan_q30(i);
        end
        sx_s[i+1]   <= sx_s[i];
        sy_s[i+1]   <= sy_s[i];
        acc_s[i+1]  <= acc_s[i];
        zero_s[i+1] <= zero_s[i];
      end
    end
  end

  // Round Q30 to Q3.13 half away from zero and clamp
  always_comb begin
    zf  = z_s[CORDIC_STEPS];
    mag = (zf < 0) ? $unsigned(-zf) : $unsigned(zf);
    rnd = (mag + Z_W'(65536)) >> 17;
    r   = (rnd > Z_W'(HEADING_MAX)) ? HEADING_MAX : rnd[15:0];
    if (zero_s[CORDIC_STEPS]) begin
      heading = '0;
    end else if (zf < 0) begin
      heading = -$signed(r);
    end else begin
      heading = $signed(r);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_s[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x        <= sx_s[CORDIC_STEPS];
      out_y        <= sy_s[CORDIC_STEPS];
      out_heading  <= heading;
      out_accepted <= acc_s[CORDIC_STEPS];
    end
  end

endmodule

// ===== sv/compass_sample_filter_heading.sv =====
// ----------------------------------------------------------------------------
// compass_sample_filter_heading - magnetometer smoothing with CORDIC heading
// Offset correction and gating in front, moving-average filters and a
// pipelined atan2 behind a short request queue.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  s_tdata: raw_x, raw_y
//  m_       out        m_tvalid/m_tready  m_tdata: smooth_x, smooth_y, heading;
//                                         m_tuser: accepted
//  cfg_     in         cfg_valid/ready    cfg_index, cfg_data
//
//  One request per cycle sustained while m_tready allows; from the queue head a
//  request passes the filter register, the fold stage, one CORDIC stage per iteration
//  and the result register. The filter recurrence is one multiply-add per axis.
//  Synchronous active-high reset clears the queue, filters and pipeline.
//  A stall on m_tready freezes the back end; the queue absorbs up to four
//  requests before s_tready drops.
// ----------------------------------------------------------------------------
module compass_sample_filter_heading import csfh_pkg::*; #(
  parameter int CORDIC_STEPS    = 16,
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] raw_x, [31:16] raw_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] smooth_x, [31:16] smooth_y, [47:32] heading
  output logic        m_tuser,   // [0] accepted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  logic [15:0] offset_x;
  logic [15:0] offset_y;
  logic [14:0] gate_limit;
  logic [16:0] alpha;

  item_t              front_item;
  item_t              head;
  logic               push;
  logic               q_full;
  logic               q_not_empty;
  logic               pop;
  logic               adv;
  logic               f_valid;
  logic signed [15:0] f_x;
  logic signed [15:0] f_y;
  logic               f_acc;
  logic signed [15:0] o_x;
  logic signed [15:0] o_y;
  logic signed [15:0] o_heading;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign push      = s_tvalid && s_tready;
  assign adv       = !m_tvalid || m_tready;
  assign m_tdata   = {o_heading, o_y, o_x};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x   <= '0;
      offset_y   <= '0;
      gate_limit <= GATE_LIMIT_RESET;
      alpha      <= ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET_X:   offset_x   <= cfg_data[15:0];
        REG_OFFSET_Y:   offset_y   <= cfg_data[15:0];
        REG_GATE_LIMIT: gate_limit <= cfg_data[14:0];
        REG_ALPHA:      alpha      <= cfg_data;
        default: ;
      endcase
    end
  end

  csfh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .raw_x      ($signed(s_tdata[15:0])),
    .raw_y      ($signed(s_tdata[31:16])),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .gate_limit (gate_limit),
    .push       (push),
    .item       (front_item)
  );

  csfh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  csfh_filter #(
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_filter (
    .clk        (clk),
    .rst        (rst),
    .alpha      (alpha),
    .item       (head),
    .item_valid (q_not_empty),
    .adv        (adv),
    .pop        (pop),
    .out_valid  (f_valid),
    .filter_x   (f_x),
    .filter_y   (f_y),
    .accepted   (f_acc)
  );

  csfh_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (f_valid),
    .in_x         (f_x),
    .in_y         (f_y),
    .in_accepted  (f_acc),
    .out_valid    (m_tvalid),
    .out_x        (o_x),
    .out_y        (o_y),
    .out_heading  (o_heading),
    .out_accepted (m_tuser)
  );

endmodule

// ===== dv/compass_heading_sb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// compass_heading_sb_pkg - expected results for the compass filter bench
// Tracks offsets, gate, alpha and both filter axes, works out smooth_x,
// smooth_y, heading and accepted for every request, and checks returned
// results in order against the expected ones.
// ----------------------------------------------------------------------------
package compass_heading_sb_pkg;
  import csfh_pkg::*;

  localparam int     CORDIC_ITERATIONS = 16;
  localparam longint ALPHA_ONE         = 64'sd65536;
  localparam longint PI_Q30_REF        = 64'sd3373259426;

  // atan(2^-i) in Q30, truncated
  localparam longint ATAN_STEP_Q30 [0:15] = '{
    64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
    64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
    64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
    64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767
  };

  typedef struct {
    logic signed [15:0] smooth_x;
    logic signed [15:0] smooth_y;
    logic signed [15:0] heading;
    logic               accepted;
  } heading_result_t;

  class heading_scoreboard;
    logic [15:0]        offset_x;
    logic [15:0]        offset_y;
    logic [14:0]        gate_limit;
    logic [16:0]        alpha;
    logic signed [15:0] filt_x;
    logic signed [15:0] filt_y;
    bit                 primed;
    heading_result_t    pending_q[$];
    int unsigned        errors;

    function new();
      offset_x   = '0;
      offset_y   = '0;
      gate_limit = GATE_LIMIT_RESET;
      alpha      = ALPHA_RESET;
      filt_x     = '0;
      filt_y     = '0;
      primed     = 1'b0;
      errors     = 0;
    endfunction

    // Apply a register write; unknown indexes are ignored
    function void set_reg(logic [3:0] index, logic [16:0] data);
      case (index)
        REG_OFFSET_X:   offset_x = data[15:0];
        REG_OFFSET_Y:   offset_y = data[15:0];
        REG_GATE_LIMIT: gate_limit = data[14:0];
        REG_ALPHA:      alpha = data;
        default: ;
      endcase
    endfunction

    // One smoothing step, alpha saturated at one, quotient toward zero
    function logic signed [15:0] blend(logic signed [15:0] sample,
                                       logic signed [15:0] prev);
      longint a;
      longint acc;
      a = (longint'(alpha) > ALPHA_ONE) ? ALPHA_ONE : longint'(alpha);
      acc = a * longint'(sample) + (ALPHA_ONE - a) * longint'(prev);
      return 16'(acc / ALPHA_ONE);
    endfunction

    // Vectoring CORDIC atan2 in Q30, rounded to Q3.13 and clamped
    function logic signed [15:0] heading_of(logic signed [15:0] fx,
                                            logic signed [15:0] fy);
      longint x, y, z, dx, dy, mag, r;
      if (fx == 0 && fy == 0)
        return '0;
      x = longint'(fx) * 16384;
      y = longint'(fy) * 16384;
      z = 0;
      // Fold the left half plane over by pi
      if (x < 0) begin
        z = (y >= 0) ? PI_Q30_REF : -PI_Q30_REF;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          z += ATAN_STEP_Q30[i];
        end else begin
          x -= dx;
          y += dy;
          z -= ATAN_STEP_Q30[i];
        end
      end
      mag = (z < 0) ? -z : z;
      r = (mag + 65536) >>> 17;
      if (r > longint'(HEADING_MAX))
        r = longint'(HEADING_MAX);
      return 16'((z < 0) ? -r : r);
    endfunction

    // Advance the filters for an accepted request and queue a result for every request
    function void note_sample(logic [15:0] raw_x, logic [15:0] raw_y);
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      int                 lim;
      heading_result_t    res;
      cx = raw_x + offset_x;
      cy = raw_y + offset_y;
      lim = int'(gate_limit);
      res.accepted = 1'b0;
      if (!primed) begin
        // first sample after reset loads the filters without gating
        filt_x = cx;
        filt_y = cy;
        primed = 1'b1;
        res.accepted = 1'b1;
      end else if (int'(cx) >= -lim && int'(cx) <= lim &&
                   int'(cy) >= -lim && int'(cy) <= lim) begin
        filt_x = blend(cx, filt_x);
        filt_y = blend(cy, filt_y);
        res.accepted = 1'b1;
      end
      res.smooth_x = filt_x;
      res.smooth_y = filt_y;
      res.heading  = heading_of(filt_x, filt_y);
      pending_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare a returned result with the oldest expected one
    task check_result(logic [47:0] data, logic user);
      heading_result_t    want;
      logic signed [15:0] got_x;
      logic signed [15:0] got_y;
      logic signed [15:0] got_h;
      if (pending_q.size() == 0) begin
        report($sformatf("result %h/%b arrived with nothing pending", data, user));
        return;
      end
      want  = pending_q.pop_front();
      got_x = data[15:0];
      got_y = data[31:16];
      got_h = data[47:32];
      if (got_x !== want.smooth_x)
        report($sformatf("smooth_x got %0d want %0d", got_x, want.smooth_x));
      if (got_y !== want.smooth_y)
        report($sformatf("smooth_y got %0d want %0d", got_y, want.smooth_y));
      if (got_h !== want.heading)
        report($sformatf("heading got %0d want %0d", got_h, want.heading));
      if (user !== want.accepted)
        report($sformatf("accepted got %b want %b", user, want.accepted));
    endtask
  endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the compass sample filter with heading
// Drives raw X/Y requests in bursts under changing offset, gate and alpha
// settings, stalls the result side on a shifting pattern with long
// hold-offs, and checks every result against the scoreboard in order.
// ----------------------------------------------------------------------------
module tb_top;
  import csfh_pkg::*;
  import compass_heading_sb_pkg::*;

  localparam logic [3:0] REG_UNUSED      = 4'hF;
  localparam int         RANDOM_PHASES   = 8;
  localparam int         ITEMS_PER_PHASE = 88;
  localparam int         TAIL_CYCLES     = 40;
  localparam int         TIMEOUT_NS      = 4_000_000;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_MOSTLY,
    READY_PULSED
  } ready_mode_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [31:0] s_tdata   = '0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [3:0]  cfg_index = '0;
  logic [16:0] cfg_data  = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic [47:0] m_tdata;
  logic        m_tuser;
  logic        cfg_ready;

  int unsigned       hold_asked = 0;
  heading_scoreboard sb = new();

  compass_sample_filter_heading i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one request and hold it until taken; valid stays high afterwards
  task automatic send_sample(input logic [15:0] x, input logic [15:0] y);
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(x, y);
  endtask

  // Write one register; valid stays high afterwards
  task automatic write_reg(input logic [3:0] index, input logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(index, data);
  endtask

  // Write every register, with junk above the offset and gate fields, then an unused index
  task automatic apply_settings(input logic [15:0] ox, input logic [15:0] oy,
                                input logic [14:0] gate, input logic [16:0] al);
    write_reg(REG_OFFSET_X, {1'($urandom_range(0, 1)), ox});
    write_reg(REG_OFFSET_Y, {1'($urandom_range(0, 1)), oy});
    write_reg(REG_GATE_LIMIT, {2'($urandom_range(0, 3)), gate});
    write_reg(REG_ALPHA, al);
    write_reg(REG_UNUSED, 17'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Stop offering and wait until every expected result is back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // Mostly corrected values around the gate, some fully random raw words
  function automatic logic [31:0] pick_sample();
    int          span;
    logic [15:0] tx;
    logic [15:0] ty;
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    span = int'(sb.gate_limit) + 2;
    tx = 16'(int'($urandom_range(0, 2 * span)) - span);
    ty = 16'(int'($urandom_range(0, 2 * span)) - span);
    return {ty - sb.offset_y, tx - sb.offset_x};
  endfunction

  // Result side: check taken results and stall on a pattern of its own
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned mode_left;
    ready_mode_t mode;
    hold_seen = 0;
    hold_left = 0;
    mode_left = 0;
    mode = READY_ALWAYS;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        sb.check_result(m_tdata, m_tuser);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = $urandom_range(60, 120);
      end
      if (mode_left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          READY_ALWAYS: m_tready <= 1'b1;
          READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
          READY_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
          default:      m_tready <= mode_left[2];
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    logic [31:0] sample;
    logic [15:0] ox;
    logic [15:0] oy;
    logic [14:0] gate;
    logic [16:0] al;
    int          sent;
    int          burst;
    int          pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First sample loads the filters even far outside the gate
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh8000);
    // Gate bounds are inclusive
    send_sample(16'sd500, -16'sd500);
    send_sample(-16'sd500, 16'sd500);
    send_sample(16'sd501, 16'sd0);
    send_sample(16'sd0, -16'sd501);
    settle();

    // Alpha of one: filters follow each accepted sample exactly
    apply_settings(16'd0, 16'd0, 15'h7fff, 17'd65536);
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd0);
    send_sample(-16'sd1, -16'sd1);
    send_sample(16'sh8000, 16'sd5);
    send_sample(16'sh7fff, 16'sh7fff);
    send_sample(-16'sd32767, 16'sd0);
    send_sample(16'sd0, -16'sd32767);
    send_sample(16'sd0, 16'sh7fff);
    send_sample(16'sd5, 16'sd0);
    settle();

    // Offsets wrap; alpha above one saturates
    apply_settings(16'h7fff, 16'h8000, 15'h7fff, 17'h1ffff);
    send_sample(16'sd1, 16'sd0);
    send_sample(16'sd0, 16'sh7fff);
    send_sample(-16'sd32767, 16'sh7fff);
    settle();

    // Zero gate and zero alpha
    apply_settings(16'd0, 16'd0, 15'd0, 17'd0);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd1, 16'sd0);
    settle();

    // Random phases under changing settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          ox = 16'h8000; oy = 16'h7fff; gate = '0; al = 17'd65536;
        end
        1: begin
          ox = 16'($urandom); oy = 16'($urandom); gate = 15'h7fff; al = '0;
        end
        2: begin
          ox = 16'($urandom); oy = 16'($urandom); gate = 15'($urandom_range(0, 1000));
          al = 17'($urandom_range(65537, 131071));
        end
        3: begin
          ox = 16'h7fff; oy = 16'h8000; gate = 15'($urandom_range(100, 4000));
          al = 17'd1;
        end
        default: begin
          ox = 16'($urandom);
          oy = 16'($urandom);
          gate = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                             : 15'($urandom_range(0, 2000));
          al = 17'($urandom_range(0, 65536));
        end
      endcase
      apply_settings(ox, oy, gate, al);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 24);
        // Hold off the result side while requests keep coming
        if (sent == 0 && (ph == 2 || ph == 5)) begin
          hold_asked++;
          burst = 48;
        end
        repeat (burst) begin
          sample = pick_sample();
          send_sample(sample[15:0], sample[31:16]);
          sent++;
        end
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          settle();
        end else if (pick >= 6) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
